// File: rtl/cnlw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnlw_pkg - shared types and constants for the character LCD nibble writer
// Bus phase codes, character mapping codes, state and result records.
// ----------------------------------------------------------------------------
package cnlw_pkg;

   // Bus phase codes
   localparam logic [3:0] PH_IDLE  = 4'd0;
   localparam logic [3:0] PH_SETRS = 4'd1;
   localparam logic [3:0] PH_SETRW = 4'd2;
   localparam logic [3:0] PH_HISET = 4'd3;
   localparam logic [3:0] PH_HIEN  = 4'd4;
   localparam logic [3:0] PH_LOSET = 4'd5;
   localparam logic [3:0] PH_LOEN  = 4'd6;
   localparam logic [3:0] PH_RDSET = 4'd7;
   localparam logic [3:0] PH_RDEN1 = 4'd8;
   localparam logic [3:0] PH_RDGAP = 4'd9;
   localparam logic [3:0] PH_RDEN2 = 4'd10;

   // Control characters taken from the input stream
   localparam logic [7:0] CHR_FORM_FEED = 8'h0C;
   localparam logic [7:0] CHR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHR_BACKSPACE = 8'h08;

   // Display commands
   localparam logic [7:0] CMD_CLEAR     = 8'h01;
   localparam logic [7:0] CMD_SHIFT     = 8'h10;
   localparam logic [7:0] CMD_DDRAM     = 8'h80;
   localparam logic [7:0] ROW2_OFFSET   = 8'h40;

   // Reset value of the phase length register
   localparam logic [15:0] PHASE_TICKS_RESET = 16'd20;

   typedef struct packed {
      logic [3:0]  phase;
      logic [15:0] tick_count;
      logic [7:0]  byte_latch;
      logic        rs_latch;
      logic        busy_sample;
   } cnlw_state_type;

   typedef struct packed {
      logic       en_pin;
      logic       rs_pin;
      logic       rw_pin;
      logic [3:0] nibble_out;
      logic       drive_data;
      logic       accepted;
      logic       idle;
   } cnlw_result_type;

endpackage

// File: rtl/cnlw_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnlw_intf - handshake channels of the character LCD nibble writer
// Tick channel (character offer and D7 level) and bus result channel.
// ----------------------------------------------------------------------------
interface cnlw_req_if;
   logic       valid;
   logic       ready;
   logic       start_req;
   logic [7:0] char_code;
   logic       busy_pin;

   modport source (output valid, output start_req, output char_code, output busy_pin,
                   input ready);
   modport sink   (input valid, input start_req, input char_code, input busy_pin,
                   output ready);
endinterface

interface cnlw_rsp_if;
   logic       valid;
   logic       ready;
   logic       en_pin;
   logic       rs_pin;
   logic       rw_pin;
   logic [3:0] nibble_out;
   logic       drive_data;
   logic       accepted;
   logic       idle;

   modport source (output valid, output en_pin, output rs_pin, output rw_pin,
                   output nibble_out, output drive_data, output accepted, output idle,
                   input ready);
   modport sink   (input valid, input en_pin, input rs_pin, input rw_pin,
                   input nibble_out, input drive_data, input accepted, input idle,
                   output ready);
endinterface

// File: rtl/cnlw_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnlw_step - one timer tick of the LCD bus sequencer
// Decodes the bus lines from the current phase and works out the next state.
// ----------------------------------------------------------------------------
module cnlw_step (
   input  cnlw_pkg::cnlw_state_type  state_cur,
   input  logic [15:0]               phase_ticks,
   input  logic                      start_req,
   input  logic [7:0]                char_code,
   input  logic                      busy_pin,
   output cnlw_pkg::cnlw_state_type  state_nxt,
   output cnlw_pkg::cnlw_result_type result
);

   logic [15:0] phase_len;
   logic [16:0] count_inc;
   logic        phase_last;

   // A zero length acts as one tick
   assign phase_len  = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
   assign count_inc  = {1'b0, state_cur.tick_count} + 17'd1;
   assign phase_last = count_inc >= {1'b0, phase_len};

   // Bus line decode from the phase held before this tick
   always_comb begin
      result = '0;
      unique case (state_cur.phase) inside
         cnlw_pkg::PH_SETRS, cnlw_pkg::PH_SETRW, cnlw_pkg::PH_HISET: begin
            result.rs_pin     = state_cur.rs_latch;
            result.drive_data = 1'b1;
            result.nibble_out = state_cur.byte_latch[7:4];
         end
         cnlw_pkg::PH_HIEN: begin
            result.rs_pin     = state_cur.rs_latch;
            result.drive_data = 1'b1;
            result.en_pin     = 1'b1;
            result.nibble_out = state_cur.byte_latch[7:4];
         end
         cnlw_pkg::PH_LOSET: begin
            result.rs_pin     = state_cur.rs_latch;
            result.drive_data = 1'b1;
            result.nibble_out = state_cur.byte_latch[3:0];
         end
         cnlw_pkg::PH_LOEN: begin
            result.rs_pin     = state_cur.rs_latch;
            result.drive_data = 1'b1;
            result.en_pin     = 1'b1;
            result.nibble_out = state_cur.byte_latch[3:0];
         end
         cnlw_pkg::PH_RDSET, cnlw_pkg::PH_RDGAP: begin
            result.rw_pin = 1'b1;
         end
         cnlw_pkg::PH_RDEN1, cnlw_pkg::PH_RDEN2: begin
            result.rw_pin = 1'b1;
            result.en_pin = 1'b1;
         end
         default: begin
            result.idle = 1'b1;
         end
      endcase

      // Unused codes behave as idle, so the idle flag doubles as "not active"
      state_nxt = state_cur;
      if (result.idle) begin
         state_nxt.phase      = cnlw_pkg::PH_IDLE;
         state_nxt.tick_count = 16'd0;
         if (start_req) begin
            result.accepted = 1'b1;
            state_nxt.phase = cnlw_pkg::PH_SETRS;
            // map control characters onto display commands
            case (char_code)
               cnlw_pkg::CHR_FORM_FEED: begin
                  state_nxt.byte_latch = cnlw_pkg::CMD_CLEAR;
                  state_nxt.rs_latch   = 1'b0;
               end
               cnlw_pkg::CHR_NEWLINE: begin
                  state_nxt.byte_latch = cnlw_pkg::CMD_DDRAM | cnlw_pkg::ROW2_OFFSET;
                  state_nxt.rs_latch   = 1'b0;
               end
               cnlw_pkg::CHR_BACKSPACE: begin
                  state_nxt.byte_latch = cnlw_pkg::CMD_SHIFT;
                  state_nxt.rs_latch   = 1'b0;
               end
               default: begin
                  state_nxt.byte_latch = char_code;
                  state_nxt.rs_latch   = 1'b1;
               end
            endcase
         end
      end else begin
         // busy flag is sampled on the last tick of the first read strobe
         if ((state_cur.phase == cnlw_pkg::PH_RDEN1) && phase_last) begin
            state_nxt.busy_sample = busy_pin;
         end
         if (phase_last) begin
            state_nxt.tick_count = 16'd0;
            if (state_cur.phase == cnlw_pkg::PH_RDEN2) begin
               state_nxt.phase = state_cur.busy_sample ? cnlw_pkg::PH_RDSET
                                                       : cnlw_pkg::PH_IDLE;
            end else begin
               state_nxt.phase = state_cur.phase + 4'd1;
            end
         end else begin
            state_nxt.tick_count = count_inc[15:0];
         end
      end
   end

endmodule

// File: rtl/char_lcd_nibble_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_core - character LCD writer on a 4-bit bus
// Maps characters to commands or data and sequences RS, RW, EN and D7..D4.
// ----------------------------------------------------------------------------
// Each item on the req channel is one timer tick and yields exactly one item on
// the rsp channel with the bus levels for that tick. The block takes one tick
// item per clock cycle, sustained while rsp.ready holds. A taken tick sits in
// the input register; one sequencer pass loads the result register once that
// is free or being emptied. While a result waits, one more tick is held in the
// input register and req.ready drops until the result leaves. The rate is set
// by the single sequencer update per tick. phase_ticks is written through
// csr_wr_en/csr_wr_data by the user only while no tick item is in flight, not
// enforced here; the new length applies from the next tick, mid-phase too.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_core (
   input  logic               clock,
   input  logic               reset,
   cnlw_req_if.sink           req,
   cnlw_rsp_if.source         rsp,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   logic [15:0]               phase_ticks_ff;
   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   logic                      s1_start_ff;
   logic [7:0]                s1_code_ff;
   logic                      s1_busy_ff;
   cnlw_pkg::cnlw_state_type  state_ff;
   cnlw_pkg::cnlw_state_type  state_in;
   cnlw_pkg::cnlw_result_type result_ff;
   cnlw_pkg::cnlw_result_type result_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      s1_advance;
   logic                      req_take;

   // Stage advances when the result register is free or being emptied
   assign s1_advance  = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready   = !s1_valid_ff || s1_advance;
   assign req_take    = req.valid && req.ready;
   assign s1_valid_in = req_take || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp.ready);

   // Sequencer pass for the tick held in the input register
   cnlw_step u_step (
      .state_cur   (state_ff),
      .phase_ticks (phase_ticks_ff),
      .start_req   (s1_start_ff),
      .char_code   (s1_code_ff),
      .busy_pin    (s1_busy_ff),
      .state_nxt   (state_in),
      .result      (result_in)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= cnlw_pkg::PHASE_TICKS_RESET;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            phase_ticks_ff <= csr_wr_data;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_start_ff <= req.start_req;
         s1_code_ff  <= req.char_code;
         s1_busy_ff  <= req.busy_pin;
      end
      if (s1_advance) begin
         result_ff <= result_in;
      end
   end

   // Result channel
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.en_pin     = result_ff.en_pin;
   assign rsp.rs_pin     = result_ff.rs_pin;
   assign rsp.rw_pin     = result_ff.rw_pin;
   assign rsp.nibble_out = result_ff.nibble_out;
   assign rsp.drive_data = result_ff.drive_data;
   assign rsp.accepted   = result_ff.accepted;
   assign rsp.idle       = result_ff.idle;

endmodule
